FILE: sv/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants for the bounded priority admission unit.
// ----------------------------------------------------------------------------
package bpa_pkg;

   localparam int SLOTS_DEFAULT    = 16;
   localparam int ID_WIDTH_DEFAULT = 10;

   localparam int CAP_W      = 5;
   localparam int RANK_W     = 10;
   localparam int FIELD_ID_W = 10;
   localparam int OCC_W      = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   typedef enum logic {
      CMD_ADMIT   = 1'b0,
      CMD_RELEASE = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type                 cmd;
      logic [FIELD_ID_W-1:0]   client_id;
      logic [RANK_W-1:0]       client_rank;
   } req_type;

   typedef struct packed {
      logic                    accepted;
      logic                    evicted;
      logic [FIELD_ID_W-1:0]   evicted_id;
      logic [OCC_W-1:0]        occupancy;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

endpackage

FILE: sv/bpa_cell.sv
// ----------------------------------------------------------------------------
// bpa_cell
// One member slot. Holds an id and a rank, folds itself into the scan token
// that walks the chain, and shifts down or loads a newcomer on commit.
// ----------------------------------------------------------------------------
module bpa_cell #(
   parameter int SLOTS    = bpa_pkg::SLOTS_DEFAULT,
   parameter int ID_WIDTH = bpa_pkg::ID_WIDTH_DEFAULT,
   parameter int IDX      = 0
) (
   input  logic                                         clock,
   input  logic [ID_WIDTH-1:0]                          req_id_i,
   input  logic [bpa_pkg::RANK_W-1:0]                   req_rank_i,
   input  logic [$clog2(SLOTS+1)-1:0]                   count_i,
   input  logic                                         commit_i,
   input  logic                                         rem_i,
   input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0]   pos_i,
   input  logic                                         app_i,
   input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0]   slot_i,
   input  logic [ID_WIDTH-1:0]                          nxt_id_i,
   input  logic [bpa_pkg::RANK_W-1:0]                   nxt_rank_i,
   input  logic                                         tok_any_i,
   input  logic [bpa_pkg::RANK_W-1:0]                   tok_rank_i,
   input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0]   tok_widx_i,
   input  logic [ID_WIDTH-1:0]                          tok_wid_i,
   input  logic                                         tok_found_i,
   input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0]   tok_fidx_i,
   output logic                                         tok_any_o,
   output logic [bpa_pkg::RANK_W-1:0]                   tok_rank_o,
   output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0]   tok_widx_o,
   output logic [ID_WIDTH-1:0]                          tok_wid_o,
   output logic                                         tok_found_o,
   output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0]   tok_fidx_o,
   output logic [ID_WIDTH-1:0]                          id_o,
   output logic [bpa_pkg::RANK_W-1:0]                   rank_o
);
   import bpa_pkg::*;

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam logic [IW-1:0] MY_IDX = IW'(IDX);

   logic [ID_WIDTH-1:0] id_ff,   id_in;
   logic [RANK_W-1:0]   rank_ff, rank_in;

   logic                tok_any_ff,   tok_any_in;
   logic [RANK_W-1:0]   tok_rank_ff,  tok_rank_in;
   logic [IW-1:0]       tok_widx_ff,  tok_widx_in;
   logic [ID_WIDTH-1:0] tok_wid_ff,   tok_wid_in;
   logic                tok_found_ff, tok_found_in;
   logic [IW-1:0]       tok_fidx_ff,  tok_fidx_in;

   logic live;

   assign live = (CW'(IDX) < count_i);

   always_comb begin
      tok_any_in   = tok_any_i;
      tok_rank_in  = tok_rank_i;
      tok_widx_in  = tok_widx_i;
      tok_wid_in   = tok_wid_i;
      tok_found_in = tok_found_i;
      tok_fidx_in  = tok_fidx_i;
      // Strictly worse takes over, so a tie stays with the lower slot.
      if (live && (!tok_any_i || rank_ff > tok_rank_i)) begin
         tok_any_in  = 1'b1;
         tok_rank_in = rank_ff;
         tok_widx_in = MY_IDX;
         tok_wid_in  = id_ff;
      end
      if (live && !tok_found_i && id_ff == req_id_i) begin
         tok_found_in = 1'b1;
         tok_fidx_in  = MY_IDX;
      end
   end

   always_comb begin
      id_in   = id_ff;
      rank_in = rank_ff;
      if (commit_i) begin
         if (app_i && slot_i == MY_IDX) begin
            id_in   = req_id_i;
            rank_in = req_rank_i;
         end else if (rem_i && MY_IDX >= pos_i) begin
            id_in   = nxt_id_i;
            rank_in = nxt_rank_i;
         end
      end
   end

   always_ff @(posedge clock) begin
      id_ff        <= id_in;
      rank_ff      <= rank_in;
      tok_any_ff   <= tok_any_in;
      tok_rank_ff  <= tok_rank_in;
      tok_widx_ff  <= tok_widx_in;
      tok_wid_ff   <= tok_wid_in;
      tok_found_ff <= tok_found_in;
      tok_fidx_ff  <= tok_fidx_in;
   end

   assign tok_any_o   = tok_any_ff;
   assign tok_rank_o  = tok_rank_ff;
   assign tok_widx_o  = tok_widx_ff;
   assign tok_wid_o   = tok_wid_ff;
   assign tok_found_o = tok_found_ff;
   assign tok_fidx_o  = tok_fidx_ff;
   assign id_o        = id_ff;
   assign rank_o      = rank_ff;

endmodule

FILE: sv/bpa_ctrl.sv
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer for the admission unit: takes a beat, times the scan down the
// cell chain, decides admit, evict or release, and drives the result beat.
// ----------------------------------------------------------------------------
module bpa_ctrl #(
   parameter int SLOTS    = bpa_pkg::SLOTS_DEFAULT,
   parameter int ID_WIDTH = bpa_pkg::ID_WIDTH_DEFAULT
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_valid,
   output logic                                         req_stall,
   input  bpa_pkg::req_type                             req_data,
   output logic                                         rsp_valid,
   input  logic                                         rsp_stall,
   output bpa_pkg::rsp_type                             rsp_data,
   input  logic                                         csr_we,
   input  logic [bpa_pkg::CAP_W-1:0]                    csr_wdata,
   input  logic                                         end_any_i,
   input  logic [bpa_pkg::RANK_W-1:0]                   end_rank_i,
   input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0]   end_widx_i,
   input  logic [ID_WIDTH-1:0]                          end_wid_i,
   input  logic                                         end_found_i,
   input  logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0]   end_fidx_i,
   output logic [ID_WIDTH-1:0]                          req_id_o,
   output logic [bpa_pkg::RANK_W-1:0]                   req_rank_o,
   output logic [$clog2(SLOTS+1)-1:0]                   count_o,
   output logic                                         commit_o,
   output logic                                         rem_o,
   output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0]   pos_o,
   output logic                                         app_o,
   output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0]   slot_o
);
   import bpa_pkg::*;

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam logic [IW-1:0] LAST_STEP = IW'(SLOTS - 1);

   state_type           state_ff, state_in;
   logic [IW-1:0]       step_ff,  step_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CAP_W-1:0]    cap_ff,   cap_in;
   cmd_type             cmd_ff,   cmd_in;
   logic [ID_WIDTH-1:0] rid_ff,   rid_in;
   logic [RANK_W-1:0]   rrank_ff, rrank_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff,   rsp_in;

   logic                full;
   logic                acc, ev, rem, app, commit;
   logic [ID_WIDTH-1:0] ev_id;
   logic [IW-1:0]       pos;
   logic [CW-1:0]       count_next;

   assign full = (32'(count_ff) >= 32'(SLOTS)) || (32'(count_ff) >= 32'(cap_ff));

   always_comb begin
      acc   = 1'b0;
      ev    = 1'b0;
      rem   = 1'b0;
      app   = 1'b0;
      pos   = end_widx_i;
      ev_id = '0;
      unique case (cmd_ff)
         CMD_ADMIT: begin
            if (!full) begin
               app = 1'b1;
               acc = 1'b1;
            end else if (end_any_i && rrank_ff < end_rank_i) begin
               rem   = 1'b1;
               app   = 1'b1;
               ev    = 1'b1;
               acc   = 1'b1;
               ev_id = end_wid_i;
            end
         end
         CMD_RELEASE: begin
            pos = end_fidx_i;
            if (end_found_i) begin
               rem = 1'b1;
               acc = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      count_next = count_ff;
      if (app && !rem) begin
         count_next = count_ff + CW'(1);
      end else if (rem && !app) begin
         count_next = count_ff - CW'(1);
      end
   end

   // The result register must be free before the set is changed.
   assign commit = (state_ff == ST_UPDATE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd_in       = cmd_ff;
      rid_in       = rid_ff;
      rrank_in     = rrank_ff;
      count_in     = count_ff;
      cap_in       = csr_we ? csr_wdata : cap_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_data.cmd;
               rid_in   = ID_WIDTH'(32'(req_data.client_id));
               rrank_in = req_data.client_rank;
               step_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            step_in = step_ff + IW'(1);
            if (step_ff == LAST_STEP) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (commit) begin
               count_in            = count_next;
               rsp_valid_in        = 1'b1;
               rsp_in.accepted     = acc;
               rsp_in.evicted      = ev;
               rsp_in.evicted_id   = FIELD_ID_W'(32'(ev_id));
               rsp_in.occupancy    = OCC_W'(32'(count_next));
               state_in            = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      rid_ff   <= rid_in;
      rrank_ff <= rrank_in;
      rsp_ff   <= rsp_in;
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign req_id_o   = rid_ff;
   assign req_rank_o = rrank_ff;
   assign count_o    = count_ff;
   assign commit_o   = commit;
   assign rem_o      = rem;
   assign pos_o      = pos;
   assign app_o      = app;
   assign slot_o     = rem ? IW'(count_ff - CW'(1)) : IW'(count_ff);

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(SLOTS))
      else $error("member count exceeds slot count");

   a_occ_matches: assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff && (rsp_ff.occupancy == OCC_W'(32'(count_ff))))
      else $error("reported occupancy differs from member count");

   a_evict_accepts: assert property (@(posedge clock) disable iff (reset)
      commit && ev |-> acc && rem && app && (count_next == count_ff))
      else $error("eviction without a matching replacement");

   a_accept_scans: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_SCAN) && (step_ff == '0))
      else $error("accepted beat did not start a scan");
`endif

endmodule

FILE: sv/bounded_priority_admission_unit.sv
// ----------------------------------------------------------------------------
// bounded_priority_admission_unit
// Capacity-limited admission set with lowest-rank priority and eviction.
// ----------------------------------------------------------------------------
// Each beat on the request channel is an admit or a release and yields exactly
// one response beat. Members live in a chain of SLOTS cells; a scan token walks
// that chain one cell per cycle to find the worst-ranked member or the first
// id match. An item is taken from the request channel, the token passes every
// cell, and the controller then commits the decision and registers the
// response. The next request is taken once the commit is done; a response
// waiting on rsp_stall holds the commit of the following item. The capacity
// register may be written only while no item is in flight; values above SLOTS
// act as SLOTS and zero counts as full.
module bounded_priority_admission_unit #(
   parameter int SLOTS    = bpa_pkg::SLOTS_DEFAULT,
   parameter int ID_WIDTH = bpa_pkg::ID_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  bpa_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output bpa_pkg::rsp_type           rsp_data,
   input  logic                       csr_we,
   input  logic [bpa_pkg::CAP_W-1:0]  csr_wdata
);
   import bpa_pkg::*;

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);

   logic                tok_any   [SLOTS];
   logic [RANK_W-1:0]   tok_rank  [SLOTS];
   logic [IW-1:0]       tok_widx  [SLOTS];
   logic [ID_WIDTH-1:0] tok_wid   [SLOTS];
   logic                tok_found [SLOTS];
   logic [IW-1:0]       tok_fidx  [SLOTS];
   logic [ID_WIDTH-1:0] cell_id   [SLOTS];
   logic [RANK_W-1:0]   cell_rank [SLOTS];

   logic [ID_WIDTH-1:0] req_id;
   logic [RANK_W-1:0]   req_rank;
   logic [CW-1:0]       count;
   logic                commit, rem, app;
   logic [IW-1:0]       pos, slot;

   bpa_ctrl #(
      .SLOTS    (SLOTS),
      .ID_WIDTH (ID_WIDTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .end_any_i   (tok_any[SLOTS-1]),
      .end_rank_i  (tok_rank[SLOTS-1]),
      .end_widx_i  (tok_widx[SLOTS-1]),
      .end_wid_i   (tok_wid[SLOTS-1]),
      .end_found_i (tok_found[SLOTS-1]),
      .end_fidx_i  (tok_fidx[SLOTS-1]),
      .req_id_o    (req_id),
      .req_rank_o  (req_rank),
      .count_o     (count),
      .commit_o    (commit),
      .rem_o       (rem),
      .pos_o       (pos),
      .app_o       (app),
      .slot_o      (slot)
   );

   for (genvar k = 0; k < SLOTS; k++) begin : g_cell
      logic                in_any, in_found;
      logic [RANK_W-1:0]   in_rank, nxt_rank;
      logic [IW-1:0]       in_widx, in_fidx;
      logic [ID_WIDTH-1:0] in_wid, nxt_id;

      // The first cell sees an empty token; the last cell has no neighbor
      // above it and keeps its own contents on a shift.
      if (k == 0) begin : g_head
         assign in_any   = 1'b0;
         assign in_rank  = '0;
         assign in_widx  = '0;
         assign in_wid   = '0;
         assign in_found = 1'b0;
         assign in_fidx  = '0;
      end else begin : g_link
         assign in_any   = tok_any[k-1];
         assign in_rank  = tok_rank[k-1];
         assign in_widx  = tok_widx[k-1];
         assign in_wid   = tok_wid[k-1];
         assign in_found = tok_found[k-1];
         assign in_fidx  = tok_fidx[k-1];
      end

      if (k == SLOTS - 1) begin : g_tail
         assign nxt_id   = cell_id[k];
         assign nxt_rank = cell_rank[k];
      end else begin : g_body
         assign nxt_id   = cell_id[k+1];
         assign nxt_rank = cell_rank[k+1];
      end

      bpa_cell #(
         .SLOTS    (SLOTS),
         .ID_WIDTH (ID_WIDTH),
         .IDX      (k)
      ) u_cell (
         .clock       (clock),
         .req_id_i    (req_id),
         .req_rank_i  (req_rank),
         .count_i     (count),
         .commit_i    (commit),
         .rem_i       (rem),
         .pos_i       (pos),
         .app_i       (app),
         .slot_i      (slot),
         .nxt_id_i    (nxt_id),
         .nxt_rank_i  (nxt_rank),
         .tok_any_i   (in_any),
         .tok_rank_i  (in_rank),
         .tok_widx_i  (in_widx),
         .tok_wid_i   (in_wid),
         .tok_found_i (in_found),
         .tok_fidx_i  (in_fidx),
         .tok_any_o   (tok_any[k]),
         .tok_rank_o  (tok_rank[k]),
         .tok_widx_o  (tok_widx[k]),
         .tok_wid_o   (tok_wid[k]),
         .tok_found_o (tok_found[k]),
         .tok_fidx_o  (tok_fidx[k]),
         .id_o        (cell_id[k]),
         .rank_o      (cell_rank[k])
      );
   end

endmodule
